// ----- hdl/tomt_pkg.sv -----
// Package for the timestamp overlap match table.
// Holds field widths, status and request codes, and the table entry type.
// No dependencies.
package tomt_pkg;

	localparam int PTS_W   = 63;
	localparam int DIM_W   = 16;
	localparam int META_W  = 32;
	localparam int PCT_W   = 32;
	localparam int ORDER_W = 64;
	localparam int LIM_W   = 5;
	localparam int IDX_W   = 1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_MATCH = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	localparam logic REQ_SUBMIT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [IDX_W-1:0] REG_INFER_DUR   = 1'b0;
	localparam logic [IDX_W-1:0] REG_ENTRY_LIMIT = 1'b1;

	localparam logic [PTS_W-1:0] INFER_DUR_RST = 63'd33333333;
	localparam logic [LIM_W-1:0] LIMIT_RST     = 5'd16;

	typedef struct packed {
		logic [PTS_W-1:0]   pts;
		logic [ORDER_W-1:0] order;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [META_W-1:0]  meta;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/tomt_if.sv -----
// Channel interfaces for the timestamp overlap match table.
// Depends on tomt_pkg for field widths.
interface tomt_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [tomt_pkg::PTS_W-1:0]    frame_pts;
	logic [tomt_pkg::PTS_W-1:0]    frame_duration;
	logic [tomt_pkg::DIM_W-1:0]    frame_width;
	logic [tomt_pkg::DIM_W-1:0]    frame_height;
	logic [tomt_pkg::META_W-1:0]   meta_handle_in;
	logic                          match_by_time;
	modport source (output valid, req_type, frame_pts, frame_duration, frame_width,
		frame_height, meta_handle_in, match_by_time, input ready);
	modport sink (input valid, req_type, frame_pts, frame_duration, frame_width,
		frame_height, meta_handle_in, match_by_time, output ready);
endinterface

interface tomt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [tomt_pkg::META_W-1:0]   meta_handle_out;
	logic [tomt_pkg::DIM_W-1:0]    source_width;
	logic [tomt_pkg::DIM_W-1:0]    source_height;
	logic [tomt_pkg::PCT_W-1:0]    match_pct;
	modport source (output valid, status, meta_handle_out, source_width, source_height,
		match_pct, input ready);
	modport sink (input valid, status, meta_handle_out, source_width, source_height,
		match_pct, output ready);
endinterface

interface tomt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tomt_pkg::IDX_W-1:0]    index;
	logic [63:0]                   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/tomt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tomt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/timestamp_overlap_match_table_core.sv -----
// Timestamp overlap match table: entry records live in one RAM (tomt_ram).
// A submit scans every slot, then writes; a latest query reads the newest entry;
// an empty table or zero span goes straight to the result; an overlap query scans
// every slot, with a 64-step divide and a serial fraction per overlapping slot.
// One word in flight; a waiting result holds the core in its last state. The next
// word is taken the cycle after the result loads. Reset clears valid bits and counters.
module timestamp_overlap_match_table_core #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tomt_req_if.sink    req,
	tomt_rsp_if.source  rsp,
	tomt_cfg_if.sink    cfg
);
	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;   // issue read of slot
	localparam logic [3:0] S_EVAL  = 4'd2;   // read data arrives
	localparam logic [3:0] S_DIV   = 4'd3;   // serial quotient
	localparam logic [3:0] S_FRAC  = 4'd4;   // serial fraction
	localparam logic [3:0] S_CMP   = 4'd5;   // compare with best
	localparam logic [3:0] S_WRITE = 4'd6;   // store new record
	localparam logic [3:0] S_LRD   = 4'd7;   // latest read
	localparam logic [3:0] S_LOUT  = 4'd8;
	localparam logic [3:0] S_MRD   = 4'd9;   // re-read matched entry
	localparam logic [3:0] S_MOUT  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q;

	// Configuration
	logic [tomt_pkg::PTS_W-1:0] dur_q;
	logic [tomt_pkg::LIM_W-1:0] limit_q;

	// Table bookkeeping
	logic [TABLE_DEPTH-1:0]        valid_q;
	logic [tomt_pkg::ORDER_W-1:0]  order_cnt_q;
	logic [AW-1:0]                 latest_q;
	logic                          latest_vld_q;

	// Item held
	logic                          req_q;
	logic [63:0]                   qs_q, qe_q;
	tomt_pkg::entry_t              new_q;
	logic [1:0]                    done_st_q;

	// Walk state
	logic [AW-1:0]                 idx_q;
	logic [CW-1:0]                 count_q;
	logic                          vic_ok_q, found_q;
	logic [AW-1:0]                 vic_q, found_idx_q;
	logic [tomt_pkg::PTS_W-1:0]    vic_pts_q;
	logic [tomt_pkg::ORDER_W-1:0]  vic_ord_q, found_ord_q, cur_ord_q;
	logic [tomt_pkg::PCT_W-1:0]    best_q;

	// Divider
	logic [63:0]                   num_q, quo_q, rem_q;
	logic [6:0]                    step_q;
	logic [6:0]                    frac_q;
	logic [39:0]                   pct_q;
	logic [tomt_pkg::PCT_W-1:0]    pct_sat;

	// RAM
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	tomt_pkg::entry_t              ram_rdata;
	logic [tomt_pkg::ENTRY_W-1:0]  ram_rbits;

	// Result register
	logic                          out_vld_q;
	logic [1:0]                    out_st_q;
	logic [tomt_pkg::META_W-1:0]   out_meta_q;
	logic [tomt_pkg::DIM_W-1:0]    out_w_q, out_h_q;
	logic [tomt_pkg::PCT_W-1:0]    out_pct_q;
	logic                          emit;

	logic                          last_idx;
	logic [CW-1:0]                 eff_lim;
	logic [AW-1:0]                 free_idx;
	logic                          free_ok;
	logic [TABLE_DEPTH-1:0]        valid_after;
	logic [63:0]                   ps, pe, rem_sh, acc_sum;
	logic                          in_a, in_b;

	assign last_idx = (idx_q == AW'(TABLE_DEPTH - 1));

	always_comb begin
		if (limit_q == '0) begin
			eff_lim = CW'(1);
		end else if (32'(limit_q) > TABLE_DEPTH) begin
			eff_lim = CW'(TABLE_DEPTH);
		end else begin
			eff_lim = CW'(limit_q);
		end
	end

	// Valid bits after the eviction decision; pick the lowest free slot.
	always_comb begin
		valid_after = valid_q;
		if (count_q >= eff_lim && vic_ok_q) begin
			valid_after[vic_q] = 1'b0;
		end
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				free_ok  = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	// Overlap test on the entry just read
	assign ps   = {1'b0, ram_rdata.pts};
	assign pe   = ps + {1'b0, dur_q};
	assign in_a = (ps >= qs_q) && (ps < qe_q);
	assign in_b = (qs_q >= ps) && (qs_q < pe);

	// Restoring divide step, and fraction accumulate step
	assign rem_sh   = {rem_q[62:0], num_q[63]};
	assign acc_sum  = num_q + rem_q;

	// Clamp the percentage to 32 bits
	assign pct_sat = (pct_q > 40'h00_FFFF_FFFF) ? 32'hFFFF_FFFF : pct_q[31:0];

	assign ram_rdata = tomt_pkg::entry_t'(ram_rbits);

	always_comb begin
		ram_we    = (state_q == S_WRITE) && free_ok;
		ram_waddr = free_idx;
		ram_raddr = idx_q;
	end

	tomt_ram #(
		.WIDTH (tomt_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (new_q),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	// Load the result register once the previous word has left or leaves now
	assign emit = ((state_q == S_LOUT) || (state_q == S_DONE)) && (!out_vld_q || rsp.ready);

	assign req.ready           = (state_q == S_IDLE);
	assign cfg.ready           = 1'b1;
	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_st_q;
	assign rsp.meta_handle_out = out_meta_q;
	assign rsp.source_width    = out_w_q;
	assign rsp.source_height   = out_h_q;
	assign rsp.match_pct       = out_pct_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q   <= tomt_pkg::INFER_DUR_RST;
			limit_q <= tomt_pkg::LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tomt_pkg::REG_INFER_DUR:   dur_q   <= cfg.data[tomt_pkg::PTS_W-1:0];
				tomt_pkg::REG_ENTRY_LIMIT: limit_q <= cfg.data[tomt_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Result valid: set on load, drop when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			order_cnt_q  <= '0;
			latest_q     <= '0;
			latest_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q        <= req.req_type;
						qs_q         <= {1'b0, req.frame_pts};
						qe_q         <= {1'b0, req.frame_pts} + {1'b0, req.frame_duration};
						new_q.pts    <= req.frame_pts;
						new_q.order  <= order_cnt_q;
						new_q.width  <= req.frame_width;
						new_q.height <= req.frame_height;
						new_q.meta   <= req.meta_handle_in;
						idx_q        <= '0;
						count_q      <= '0;
						vic_ok_q     <= 1'b0;
						found_q      <= 1'b0;
						best_q       <= '0;
						if (req.req_type == tomt_pkg::REQ_SUBMIT) begin
							state_q <= S_SCAN;
						end else if (!latest_vld_q) begin
							done_st_q <= tomt_pkg::ST_EMPTY;
							state_q   <= S_DONE;
						end else if (!req.match_by_time) begin
							idx_q   <= latest_q;
							state_q <= S_LRD;
						end else if (dur_q == '0) begin
							done_st_q <= tomt_pkg::ST_NO_MATCH;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_SCAN;
					if (valid_q[idx_q]) begin
						if (req_q == tomt_pkg::REQ_SUBMIT) begin
							count_q <= count_q + CW'(1);
							if (!vic_ok_q || ram_rdata.pts < vic_pts_q ||
							    (ram_rdata.pts == vic_pts_q && ram_rdata.order < vic_ord_q)) begin
								vic_ok_q  <= 1'b1;
								vic_q     <= idx_q;
								vic_pts_q <= ram_rdata.pts;
								vic_ord_q <= ram_rdata.order;
							end
						end else if (in_a || in_b) begin
							num_q     <= in_a ? (qe_q - ps) : (pe - qs_q);
							quo_q     <= '0;
							rem_q     <= '0;
							step_q    <= '0;
							cur_ord_q <= ram_rdata.order;
							state_q   <= S_DIV;
						end
					end
					if (state_q == S_EVAL && !(valid_q[idx_q] && req_q == tomt_pkg::REQ_QUERY
					    && (in_a || in_b))) begin
						if (last_idx) begin
							state_q <= (req_q == tomt_pkg::REQ_SUBMIT) ? S_WRITE : S_MRD;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				S_DIV: begin
					// one quotient bit per cycle
					num_q <= {num_q[62:0], 1'b0};
					if (rem_sh >= {1'b0, dur_q}) begin
						rem_q <= rem_sh - {1'b0, dur_q};
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					step_q <= step_q + 7'd1;
					if (step_q == 7'd63) begin
						state_q <= S_FRAC;
						step_q  <= '0;
						frac_q  <= '0;
						num_q   <= '0;
					end
				end
				S_FRAC: begin
					// num_q is the accumulator, rem_q the remainder
					if (quo_q > 64'hFFFF_FFFF) begin
						pct_q   <= 40'h00_FFFF_FFFF;
						state_q <= S_CMP;
					end else if (step_q == 7'd100) begin
						pct_q   <= 40'(quo_q[31:0]) * 40'd100 + 40'(frac_q)
							+ 40'({num_q, 1'b0} >= {1'b0, dur_q});
						state_q <= S_CMP;
					end else begin
						if (acc_sum >= {1'b0, dur_q}) begin
							num_q  <= acc_sum - {1'b0, dur_q};
							frac_q <= frac_q + 7'd1;
						end else begin
							num_q <= acc_sum;
						end
						step_q <= step_q + 7'd1;
					end
				end
				S_CMP: begin
					if (pct_q != '0) begin
						if (pct_sat > best_q ||
						    (pct_sat == best_q && found_q && cur_ord_q < found_ord_q)) begin
							best_q      <= pct_sat;
							found_q     <= 1'b1;
							found_idx_q <= idx_q;
							found_ord_q <= cur_ord_q;
						end
					end
					if (last_idx) begin
						state_q <= S_MRD;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_SCAN;
					end
				end
				S_MRD: begin
					if (found_q) begin
						idx_q   <= found_idx_q;
						state_q <= S_LRD;
					end else begin
						done_st_q <= tomt_pkg::ST_NO_MATCH;
						state_q   <= S_DONE;
					end
				end
				S_LRD: begin
					state_q <= S_LOUT;
				end
				S_LOUT: begin
					// hold the read data until the result register is free
					if (emit) begin
						out_st_q   <= tomt_pkg::ST_OK;
						out_meta_q <= ram_rdata.meta;
						out_w_q    <= ram_rdata.width;
						out_h_q    <= ram_rdata.height;
						out_pct_q  <= best_q;
						state_q    <= S_IDLE;
					end
				end
				S_WRITE: begin
					valid_q <= valid_after;
					if (free_ok) begin
						valid_q[free_idx] <= 1'b1;
						order_cnt_q       <= order_cnt_q + 64'd1;
						latest_q          <= free_idx;
						latest_vld_q      <= 1'b1;
					end
					done_st_q <= tomt_pkg::ST_OK;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					// submit, empty and no-match results carry zero payload
					if (emit) begin
						out_st_q   <= done_st_q;
						out_meta_q <= '0;
						out_w_q    <= '0;
						out_h_q    <= '0;
						out_pct_q  <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
